// File: sv/wsfm_pkg.sv
// Package for the masked WebSocket frame encoder.
// Holds the request types, job encoding and header constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wsfm_pkg;

  localparam int KEY_W      = 32;
  localparam int OPCODE_W   = 4;
  localparam int LEN_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int STEP_W     = 3;

  localparam logic [BYTE_W-1:0] FIN_BIT       = 8'd128;
  localparam logic [BYTE_W-1:0] MASK_BIT      = 8'd128;
  localparam logic [BYTE_W-1:0] EXT_LEN_CODE  = 8'd126;
  localparam logic [LEN_W-1:0]  SHORT_LEN_MAX = 16'd125;

  localparam logic [KEY_W-1:0]    KEY_RESET    = 32'h1323471F;
  localparam logic [OPCODE_W-1:0] OPCODE_RESET = 4'd1;

  localparam logic [STEP_W-1:0] SHORT_LAST_STEP = 3'd5;
  localparam logic [STEP_W-1:0] LONG_LAST_STEP  = 3'd7;

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_PAYLOAD = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_MASK_KEY     = 1'b0,
    REG_FRAME_OPCODE = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    JOB_START  = 2'd0,
    JOB_DATA   = 2'd1,
    JOB_MISUSE = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t            kind;
    logic [BYTE_W-1:0]    data;
    logic                 eof;
    logic [LEN_W-1:0]     len;
    logic [OPCODE_W-1:0]  opcode;
    logic [KEY_W-1:0]     key;
  } job_t;

  function automatic logic [BYTE_W-1:0] key_byte(input logic [KEY_W-1:0] key,
                                                 input logic [1:0] pos);
    logic [BYTE_W-1:0] b;
    case (pos)
      2'd0: b = key[31:24];
      2'd1: b = key[23:16];
      2'd2: b = key[15:8];
      default: b = key[7:0];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: sv/websocket_frame_masker.sv
// Masked WebSocket client frame encoder, top level.
// A request is written into the job queue and then into the result register before its first result byte.
// Throughput: one result byte per cycle while results are popped; payload requests one
// per cycle while the queue is not full; a start request occupies the back end for one step per header byte.
// Reset (rst, synchronous): no frame open, queue and result register empty,
// key 0x1323471F and opcode 1.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_masker import wsfm_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic                cfg_index,
  input  wire logic [KEY_W-1:0]    cfg_data,
  input  wire logic                push,
  output logic                     full,
  input  wire logic                command,
  input  wire logic [LEN_W-1:0]    message_length,
  input  wire logic [BYTE_W-1:0]   data_byte,
  output logic                     empty,
  input  wire logic                pop,
  output logic [BYTE_W-1:0]        out_byte,
  output logic                     end_of_run,
  output logic                     end_of_frame,
  output logic                     misuse_flag
);

  logic [KEY_W-1:0]    mask_key;
  logic [OPCODE_W-1:0] frame_opcode;
  logic                job_push;
  job_t                job;
  job_t                head;
  logic                q_full;
  logic                q_empty;
  logic                q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_key     <= KEY_RESET;
      frame_opcode <= OPCODE_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_MASK_KEY:     mask_key     <= cfg_data;
        REG_FRAME_OPCODE: frame_opcode <= cfg_data[OPCODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign full = q_full;

  wsfm_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .command        (command),
    .message_length (message_length),
    .data_byte      (data_byte),
    .mask_key       (mask_key),
    .frame_opcode   (frame_opcode),
    .q_full         (q_full),
    .job_push       (job_push),
    .job            (job)
  );

  wsfm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (job_push),
    .wr_job  (job),
    .full    (q_full),
    .rd      (q_pop),
    .head    (head),
    .q_empty (q_empty)
  );

  wsfm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .out_byte     (out_byte),
    .end_of_run   (end_of_run),
    .end_of_frame (end_of_frame),
    .misuse_flag  (misuse_flag)
  );

endmodule

`default_nettype wire

// File: sv/wsfm_front.sv
// Front end: accepts requests, tracks frame state and masks payload bytes.
// Emits one job per accepted request into the job queue. Depends on wsfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsfm_front import wsfm_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire logic                command,
  input  wire logic [LEN_W-1:0]    message_length,
  input  wire logic [BYTE_W-1:0]   data_byte,
  input  wire logic [KEY_W-1:0]    mask_key,
  input  wire logic [OPCODE_W-1:0] frame_opcode,
  input  wire logic                q_full,
  output logic                     job_push,
  output job_t                     job
);

  logic [LEN_W-1:0] bytes_remaining, bytes_remaining_next;
  logic [1:0]       key_position, key_position_next;
  logic             frame_open, frame_open_next;
  logic             accept;

  assign accept   = push && !q_full;
  assign job_push = accept;

  always_comb begin
    bytes_remaining_next = bytes_remaining;
    key_position_next    = key_position;
    frame_open_next      = frame_open;
    job.kind   = JOB_MISUSE;
    job.data   = '0;
    job.eof    = 1'b0;
    job.len    = message_length;
    job.opcode = frame_opcode;
    job.key    = mask_key;
    if (cmd_t'(command) == CMD_START) begin
      job.kind             = JOB_START;
      bytes_remaining_next = message_length;
      key_position_next    = 2'd0;
      frame_open_next      = (message_length != '0);
    end else if (frame_open) begin
      job.kind             = JOB_DATA;
      job.data             = data_byte ^ key_byte(mask_key, key_position);
      bytes_remaining_next = bytes_remaining - LEN_W'(1);
      key_position_next    = key_position + 2'd1;
      job.eof              = (bytes_remaining == LEN_W'(1));
      frame_open_next      = (bytes_remaining != LEN_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      key_position    <= '0;
      frame_open      <= 1'b0;
    end else if (accept) begin
      bytes_remaining <= bytes_remaining_next;
      key_position    <= key_position_next;
      frame_open      <= frame_open_next;
    end
  end

`ifndef SYNTHESIS
  a_open_has_bytes: assert property (@(posedge clk) disable iff (rst)
    frame_open |-> bytes_remaining != '0)
    else $error("frame open with no bytes remaining");
`endif

endmodule

`default_nettype wire

// File: sv/wsfm_queue.sv
// Short job queue between front and back ends.
// Register-based, first word visible at the head. Depends on wsfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsfm_queue import wsfm_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  job_t      wr_job,
  output logic      full,
  input  wire logic rd,
  output job_t      head,
  output logic      q_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full    = (count == FULL_CNT);
  assign q_empty = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !q_empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count beyond depth");
  a_no_read_empty: assert property (@(posedge clk) disable iff (rst)
    rd |-> !q_empty)
    else $error("read from empty queue");
`endif

endmodule

`default_nettype wire

// File: sv/wsfm_back.sv
// Back end: expands jobs into frame bytes and holds the result register.
// Start jobs take six or eight steps, other jobs one. Depends on wsfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsfm_back import wsfm_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  job_t              head,
  input  wire logic         q_empty,
  output logic              q_pop,
  input  wire logic         pop,
  output logic              empty,
  output logic [BYTE_W-1:0] out_byte,
  output logic              end_of_run,
  output logic              end_of_frame,
  output logic              misuse_flag
);

  logic [STEP_W-1:0] step;
  logic              out_valid;
  logic              out_free;
  logic              is_short;
  logic [STEP_W-1:0] last_step;
  logic [STEP_W-1:0] key_step;
  logic [BYTE_W-1:0] cur_byte;
  logic              cur_last;
  logic              cur_eof;
  logic              cur_mis;

  assign out_free  = !out_valid || pop;
  assign empty     = !out_valid;
  assign is_short  = (head.len <= SHORT_LEN_MAX);
  assign last_step = is_short ? SHORT_LAST_STEP : LONG_LAST_STEP;
  assign key_step  = is_short ? step - STEP_W'(2) : step - STEP_W'(4);

  always_comb begin
    cur_byte = '0;
    cur_last = 1'b1;
    cur_eof  = 1'b0;
    cur_mis  = 1'b0;
    case (head.kind)
      JOB_START: begin
        cur_last = (step == last_step);
        cur_eof  = cur_last && (head.len == '0);
        if (step == 3'd0) begin
          cur_byte = FIN_BIT | {4'd0, head.opcode};
        end else if (step == 3'd1) begin
          cur_byte = is_short ? (MASK_BIT | head.len[BYTE_W-1:0]) : (MASK_BIT | EXT_LEN_CODE);
        end else if (!is_short && step == 3'd2) begin
          cur_byte = head.len[15:8];
        end else if (!is_short && step == 3'd3) begin
          cur_byte = head.len[7:0];
        end else begin
          cur_byte = key_byte(head.key, key_step[1:0]);
        end
      end
      JOB_DATA: begin
        cur_byte = head.data;
        cur_eof  = head.eof;
      end
      default: begin
        cur_mis = 1'b1;
      end
    endcase
  end

  assign q_pop = out_free && !q_empty && cur_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else if (out_free) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        step <= cur_last ? '0 : step + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && !q_empty) begin
      out_byte     <= cur_byte;
      end_of_run   <= cur_last;
      end_of_frame <= cur_eof;
      misuse_flag  <= cur_mis;
    end
  end

`ifndef SYNTHESIS
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid && $stable(out_byte))
    else $error("waiting result lost or changed");
`endif

endmodule

`default_nettype wire
